[sv/i2cgpio_pkg.sv]
// ----------------------------------------------------------------------------
// i2cgpio_pkg
// Types, codes and constants of the two-port i2c gpio expander bridge.
// ----------------------------------------------------------------------------
package i2cgpio_pkg;

   localparam int unsigned PinsPerPort = 8;

   typedef struct packed {
      logic [2:0] kind;
      logic [3:0] request;
      logic [7:0] data;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       read_valid;
      logic [7:0] read_data;
      logic [1:0] dev_op;
      logic [7:0] dev_addr_byte;
      logic [4:0] dev_reg;
      logic [7:0] dev_data;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [4:0] dev_reg;
      logic [7:0] dev_data;
   } init_write_type;

   typedef enum logic [1:0] {
      SelDir  = 2'd0,
      SelLat  = 2'd1,
      SelGpio = 2'd2,
      SelPull = 2'd3
   } sel_type;

   localparam logic [2:0] KindSelect = 3'd0;
   localparam logic [2:0] KindWrite  = 3'd1;
   localparam logic [2:0] KindRead   = 3'd2;
   localparam logic [2:0] KindReply  = 3'd3;
   localparam logic [2:0] KindOpen   = 3'd4;

   localparam logic [1:0] StatusOk     = 2'd0;
   localparam logic [1:0] StatusUnrec  = 2'd1;
   localparam logic [1:0] StatusAccess = 2'd2;

   localparam logic [1:0] OpNone  = 2'd0;
   localparam logic [1:0] OpWrite = 2'd1;
   localparam logic [1:0] OpRead  = 2'd2;

   localparam logic [0:0] CsrAccessMode   = 1'd0;
   localparam logic [0:0] CsrSlaveAddress = 1'd1;

   localparam logic [1:0] AccessModeReset   = 2'd2;
   localparam logic [6:0] SlaveAddressReset = 7'd32;

   localparam logic [4:0] RegIodir  = 5'h00;
   localparam logic [4:0] RegGppu   = 5'h06;
   localparam logic [4:0] RegGpio   = 5'h09;
   localparam logic [4:0] RegOlat   = 5'h0A;
   localparam logic [4:0] RegIocon  = 5'h0B;
   localparam logic [4:0] PortBOfs  = 5'h10;
   localparam logic [7:0] IoconInit = 8'hA0;

   localparam logic [7:0] DirReset = 8'hFF;
   localparam logic [7:0] LatReset = 8'h00;
   localparam logic [7:0] OdReset  = 8'h00;

   localparam logic [3:0] MaxSelectCode = 4'd11;
   localparam logic [2:0] InitLastStep  = 3'd6;

   // device initialization sequence after an open beat
   function automatic init_write_type init_write(input logic [2:0] step);
      init_write_type w;
      case (step)
         3'd0: w = '{dev_reg: RegIocon, dev_data: IoconInit};
         3'd1: w = '{dev_reg: RegGppu, dev_data: 8'h00};
         3'd2: w = '{dev_reg: PortBOfs | RegGppu, dev_data: 8'h00};
         3'd3: w = '{dev_reg: RegIodir, dev_data: DirReset};
         3'd4: w = '{dev_reg: PortBOfs | RegIodir, dev_data: DirReset};
         3'd5: w = '{dev_reg: RegOlat, dev_data: LatReset};
         default: w = '{dev_reg: PortBOfs | RegOlat, dev_data: LatReset};
      endcase
      return w;
   endfunction

endpackage

[sv/i2c_gpio_expander_bridge.sv]
// beats are held in the input stage and results registered in the output stage;
// one result per cycle, single-result beats taken every cycle, while the output
// is not stalled; latch writes and open beats hold the input stage to their last result
// reset: synchronous, active high; port a direction selected, shadows at their
// power-up values, access_mode 2 and slave_address 32
// ----------------------------------------------------------------------------
// i2c_gpio_expander_bridge
// Host front end for a two-port i2c gpio expander with open-drain emulation.
// ----------------------------------------------------------------------------
module i2c_gpio_expander_bridge #(
   parameter int unsigned PINS_PER_PORT = i2cgpio_pkg::PinsPerPort
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  i2cgpio_pkg::req_type req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output i2cgpio_pkg::rsp_type rsp_item,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [0:0]           csr_index,
   input  logic [6:0]           csr_data
);

   localparam logic [7:0] PinMask = 8'((9'd1 << PINS_PER_PORT) - 9'd1);

   logic                 in_valid_ff, in_valid_in;
   i2cgpio_pkg::req_type in_item_ff, in_item_in;
   logic [2:0]           seq_ff, seq_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   i2cgpio_pkg::rsp_type rsp_ff, rsp_in;

   logic [1:0] access_mode_ff;
   logic [6:0] slave_address_ff;

   logic                 port_ff;
   i2cgpio_pkg::sel_type sel_ff;
   logic                 pending_ff;
   logic [7:0]           dir_ff [2];
   logic [7:0]           lat_ff [2];
   logic [7:0]           od_ff  [2];

   logic                        out_free, fire, accept, write_ok, read_ok;
   logic [4:0]                  ofs;
   logic [7:0]                  cur_dir, cur_lat, cur_od, d, lat_out, dir_out;
   i2cgpio_pkg::rsp_type        cur;
   i2cgpio_pkg::init_write_type init_w;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign fire     = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || (out_free && cur.last);
   assign accept   = req_valid && req_ready;

   assign write_ok = access_mode_ff[0] || access_mode_ff[1];
   assign read_ok  = access_mode_ff[1] || !access_mode_ff[0];
   assign ofs      = port_ff ? i2cgpio_pkg::PortBOfs : 5'h00;
   assign cur_dir  = dir_ff[port_ff];
   assign cur_lat  = lat_ff[port_ff];
   assign cur_od   = od_ff[port_ff];
   assign d        = in_item_ff.data;
   assign init_w   = i2cgpio_pkg::init_write(seq_ff);

   // open-drain emulation, pins above the port width pass through
   assign lat_out = (d & ~PinMask) | (d & ~cur_dir & ~cur_od & PinMask);
   assign dir_out = (cur_dir & ~PinMask) | ((cur_dir | (cur_od & d)) & PinMask);

   always_comb begin
      cur      = '0;
      cur.last = 1'b1;
      case (in_item_ff.kind)
         i2cgpio_pkg::KindSelect: begin
            if (in_item_ff.request > i2cgpio_pkg::MaxSelectCode) begin
               cur.status = i2cgpio_pkg::StatusUnrec;
            end
         end
         i2cgpio_pkg::KindWrite: begin
            if (!write_ok) begin
               cur.status = i2cgpio_pkg::StatusAccess;
            end else if (pending_ff) begin
               cur.dev_op = i2cgpio_pkg::OpNone;
            end else if (sel_ff == i2cgpio_pkg::SelDir) begin
               cur.dev_op   = i2cgpio_pkg::OpWrite;
               cur.dev_reg  = ofs | i2cgpio_pkg::RegIodir;
               cur.dev_data = d;
            end else if (sel_ff == i2cgpio_pkg::SelPull) begin
               cur.dev_op   = i2cgpio_pkg::OpWrite;
               cur.dev_reg  = ofs | i2cgpio_pkg::RegGppu;
               cur.dev_data = d;
            end else if (seq_ff == 3'd0) begin
               cur.dev_op   = i2cgpio_pkg::OpWrite;
               cur.dev_reg  = ofs | i2cgpio_pkg::RegOlat;
               cur.dev_data = lat_out;
               cur.last     = 1'b0;
            end else begin
               cur.dev_op   = i2cgpio_pkg::OpWrite;
               cur.dev_reg  = ofs | i2cgpio_pkg::RegIodir;
               cur.dev_data = dir_out;
            end
         end
         i2cgpio_pkg::KindRead: begin
            if (!read_ok) begin
               cur.status = i2cgpio_pkg::StatusAccess;
            end else if (pending_ff) begin
               cur.read_valid = 1'b1;
               cur.read_data  = cur_od;
            end else if (sel_ff == i2cgpio_pkg::SelDir) begin
               cur.read_valid = 1'b1;
               cur.read_data  = cur_dir;
            end else if (sel_ff == i2cgpio_pkg::SelLat) begin
               cur.read_valid = 1'b1;
               cur.read_data  = cur_lat;
            end else if (sel_ff == i2cgpio_pkg::SelGpio) begin
               cur.dev_op  = i2cgpio_pkg::OpRead;
               cur.dev_reg = ofs | i2cgpio_pkg::RegGpio;
            end else begin
               cur.dev_op  = i2cgpio_pkg::OpRead;
               cur.dev_reg = ofs | i2cgpio_pkg::RegGppu;
            end
         end
         i2cgpio_pkg::KindReply: begin
            cur.read_valid = 1'b1;
            cur.read_data  = d;
         end
         i2cgpio_pkg::KindOpen: begin
            cur.dev_op   = i2cgpio_pkg::OpWrite;
            cur.dev_reg  = init_w.dev_reg;
            cur.dev_data = init_w.dev_data;
            cur.last     = (seq_ff == i2cgpio_pkg::InitLastStep);
         end
         default: begin
            cur.status = i2cgpio_pkg::StatusUnrec;
         end
      endcase
      if (cur.dev_op == i2cgpio_pkg::OpWrite) begin
         cur.dev_addr_byte = {slave_address_ff, 1'b0};
      end else if (cur.dev_op == i2cgpio_pkg::OpRead) begin
         cur.dev_addr_byte = {slave_address_ff, 1'b1};
      end
   end

   always_comb begin
      in_item_in   = in_item_ff;
      in_valid_in  = in_valid_ff;
      seq_in       = seq_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (fire) begin
         rsp_in       = cur;
         rsp_valid_in = 1'b1;
         if (cur.last) begin
            in_valid_in = 1'b0;
            seq_in      = 3'd0;
         end else begin
            seq_in = seq_ff + 3'd1;
         end
      end
      if (accept) begin
         in_item_in  = req_item;
         in_valid_in = 1'b1;
         seq_in      = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      rsp_ff     <= rsp_in;
      if (reset) begin
         in_valid_ff  <= 1'b0;
         seq_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         access_mode_ff   <= i2cgpio_pkg::AccessModeReset;
         slave_address_ff <= i2cgpio_pkg::SlaveAddressReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            i2cgpio_pkg::CsrAccessMode:   access_mode_ff   <= csr_data[1:0];
            i2cgpio_pkg::CsrSlaveAddress: slave_address_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // state moves on when a beat's last result is registered
   always_ff @(posedge clock) begin
      if (reset) begin
         port_ff    <= 1'b0;
         sel_ff     <= i2cgpio_pkg::SelDir;
         pending_ff <= 1'b0;
         dir_ff     <= '{i2cgpio_pkg::DirReset, i2cgpio_pkg::DirReset};
         lat_ff     <= '{i2cgpio_pkg::LatReset, i2cgpio_pkg::LatReset};
         od_ff      <= '{i2cgpio_pkg::OdReset, i2cgpio_pkg::OdReset};
      end else if (fire && cur.last) begin
         case (in_item_ff.kind)
            i2cgpio_pkg::KindSelect: begin
               if (in_item_ff.request <= i2cgpio_pkg::MaxSelectCode) begin
                  port_ff <= in_item_ff.request[0];
                  unique case (in_item_ff.request[3:1]) inside
                     3'd0: sel_ff <= i2cgpio_pkg::SelDir;
                     3'd1: begin
                        sel_ff     <= i2cgpio_pkg::SelDir;
                        pending_ff <= 1'b1;
                     end
                     3'd2, 3'd3: sel_ff <= i2cgpio_pkg::SelLat;
                     3'd4: sel_ff <= i2cgpio_pkg::SelGpio;
                     default: sel_ff <= i2cgpio_pkg::SelPull;
                  endcase
               end
            end
            i2cgpio_pkg::KindWrite: begin
               if (write_ok) begin
                  if (pending_ff) begin
                     pending_ff     <= 1'b0;
                     od_ff[port_ff] <= d;
                  end else if (sel_ff == i2cgpio_pkg::SelDir) begin
                     dir_ff[port_ff] <= d;
                  end else if (sel_ff != i2cgpio_pkg::SelPull) begin
                     lat_ff[port_ff] <= d;
                  end
               end
            end
            i2cgpio_pkg::KindRead: begin
               if (read_ok) begin
                  pending_ff <= 1'b0;
               end
            end
            i2cgpio_pkg::KindOpen: begin
               port_ff    <= 1'b0;
               sel_ff     <= i2cgpio_pkg::SelDir;
               pending_ff <= 1'b0;
               dir_ff     <= '{i2cgpio_pkg::DirReset, i2cgpio_pkg::DirReset};
               lat_ff     <= '{i2cgpio_pkg::LatReset, i2cgpio_pkg::LatReset};
               od_ff      <= '{i2cgpio_pkg::OdReset, i2cgpio_pkg::OdReset};
            end
            default: ;
         endcase
      end
   end

`ifndef ASSERT_OFF
   // a burst in flight keeps its input beat held
   a_burst_holds_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.last) |-> in_valid_ff)
      else $error("non-final result without held input beat");

   // an error result ends its beat and drives no device access
   a_error_is_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != i2cgpio_pkg::StatusOk)
         |-> (rsp_ff.last && rsp_ff.dev_op == i2cgpio_pkg::OpNone))
      else $error("error result with device access or follow-on");

   // a host answer never comes with a device access
   a_read_no_dev: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.read_valid) |-> (rsp_ff.dev_op == i2cgpio_pkg::OpNone))
      else $error("host read data together with device access");
`endif

endmodule
